// ===== hdl/sra_pkg.sv =====
// Shared constants, types and character mapping for the signed radix-to-ASCII converter.
package sra_pkg;

   localparam int unsigned VALUE_BITS       = 32;
   localparam int unsigned VALUE_WIDTH_DFLT = 32;
   localparam int unsigned CHAR_BITS        = 7;
   localparam int unsigned CHAR_COUNT_BITS  = 6;
   localparam int unsigned RADIX_BITS       = 5;
   localparam int unsigned DIGIT_BITS       = 4;
   localparam int unsigned STEP_BITS        = 8;
   localparam int unsigned CSR_INDEX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH   = RADIX_BITS;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 4'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2D;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIX      = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_CASE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d,
                                                           input logic upper);
      logic [CHAR_BITS-1:0] res;
      if (d < DIGIT_TEN) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else if (upper) begin
         res = CHAR_UPPER_A + CHAR_BITS'(d - DIGIT_TEN);
      end else begin
         res = CHAR_LOWER_A + CHAR_BITS'(d - DIGIT_TEN);
      end
      return res;
   endfunction

endpackage

// ===== hdl/sra_req_if.sv =====
// Input channel carrying one signed value per item.
interface sra_req_if;
   import sra_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source(output valid, output value, input ready);
   modport sink(input valid, input value, output ready);
endinterface

// ===== hdl/sra_rsp_if.sv =====
// Result channel carrying one ASCII character per item.
interface sra_rsp_if;
   import sra_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CHAR_BITS-1:0]       character;
   logic [CHAR_COUNT_BITS-1:0] char_count;
   logic                       last;

   modport source(output valid, output character, output char_count, output last, input ready);
   modport sink(input valid, input character, input char_count, input last, output ready);
endinterface

// ===== hdl/signed_radix_to_ascii.sv =====
// Signed integer to ASCII text converter in a configurable radix from 2 to 16.
// A new value is accepted only in the idle state, once the previous item's last character is loaded for output.
// The shared divider yields eight quotient bits a cycle; characters go out one per cycle
// while the result channel is ready.
// Reset: synchronous; radix 10, lower case, idle; the digit store is not cleared.
module signed_radix_to_ascii #(
   parameter int unsigned VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DFLT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sra_req_if.sink                              req_chan,
   sra_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [sra_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sra_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import sra_pkg::*;

   localparam int unsigned DIV_STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int unsigned PAD_WIDTH = DIV_STEPS * STEP_BITS;
   localparam int unsigned IDX_W     = $clog2(VALUE_WIDTH);
   localparam int unsigned CNT_W     = $clog2(VALUE_WIDTH + 1);

   state_type state_ff, state_in;

   logic [RADIX_BITS-1:0]      radix_ff;
   logic                       upper_ff;
   logic                       neg_ff, neg_in;
   logic [CNT_W-1:0]           digit_total_ff, digit_total_in, rd_total, rd_next;
   logic [CHAR_COUNT_BITS-1:0] count_ff, count_in;
   logic [DIGIT_BITS-1:0]      digit_store_ff [VALUE_WIDTH];
   logic [DIGIT_BITS-1:0]      rd_digit_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]       rsp_char_ff, rsp_char_in;
   logic [CHAR_COUNT_BITS-1:0] rsp_count_ff;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       accept, out_free, load_out, req_ready;
   logic                       div_start, div_done, more_digits, digit_write;
   logic [VALUE_WIDTH-1:0]     value_bits, magnitude;
   logic [PAD_WIDTH-1:0]       div_operand, div_quotient;
   logic [DIGIT_BITS-1:0]      div_remainder;
   logic [RADIX_BITS-1:0]      eff_radix;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         upper_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RADIX:      radix_ff <= csr_write_data;
            CSR_UPPER_CASE: upper_ff <= csr_write_data[0];
         endcase
      end
   end

   assign eff_radix   = clamp_radix(radix_ff);
   assign value_bits  = req_chan.value[VALUE_WIDTH-1:0];
   assign magnitude   = value_bits[VALUE_WIDTH-1] ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;
   assign accept      = req_chan.valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign more_digits = div_quotient != '0;
   assign rd_total    = digit_total_ff - CNT_W'(1);
   assign rd_next     = digit_total_in - CNT_W'(1);

   sra_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .operand  (div_operand),
      .radix    (eff_radix),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done && !more_digits) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && (digit_total_ff == CNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      div_start   = 1'b0;
      digit_write = 1'b0;
      load_out    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_chan.valid;
         end
         ST_DIVIDE: begin
            digit_write = div_done;
            div_start   = div_done && more_digits;
         end
         ST_SIGN: begin
            load_out = out_free;
         end
         ST_EMIT: begin
            load_out = out_free;
         end
      endcase
   end

   assign req_chan.ready = req_ready;
   assign div_operand    = accept ? PAD_WIDTH'(magnitude) : div_quotient;

   always_comb begin
      neg_in         = neg_ff;
      digit_total_in = digit_total_ff;
      count_in       = count_ff;
      if (accept) begin
         neg_in         = value_bits[VALUE_WIDTH-1];
         digit_total_in = '0;
         count_in       = '0;
      end else if (digit_write) begin
         digit_total_in = digit_total_ff + CNT_W'(1);
      end else if (load_out) begin
         count_in = count_ff + CHAR_COUNT_BITS'(1);
         if (state_ff == ST_EMIT) begin
            digit_total_in = rd_total;
         end
      end
   end

   always_comb begin
      rsp_char_in  = (state_ff == ST_SIGN) ? CHAR_MINUS : digit_to_ascii(rd_digit_ff, upper_ff);
      rsp_last_in  = (state_ff == ST_EMIT) && (digit_total_ff == CNT_W'(1));
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         digit_total_ff <= '0;
         count_ff       <= '0;
         neg_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         digit_total_ff <= digit_total_in;
         count_ff       <= count_in;
         neg_ff         <= neg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // hold the top digit of the store; bypass the digit being written
   always_ff @(posedge clock) begin
      if (digit_write) begin
         digit_store_ff[digit_total_ff[IDX_W-1:0]] <= div_remainder;
         rd_digit_ff                               <= div_remainder;
      end else begin
         rd_digit_ff <= digit_store_ff[rd_next[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_char_ff  <= rsp_char_in;
         rsp_count_ff <= count_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.character  = rsp_char_ff;
   assign rsp_chan.char_count = rsp_count_ff;
   assign rsp_chan.last       = rsp_last_ff;

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (digit_total_ff != '0))
      else $error("emit state with no digits left");

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIVIDE) && (digit_total_ff == '0) && (count_ff == '0))
      else $error("accepted item did not start division");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0) &&
                       (rsp_count_ff <= CHAR_COUNT_BITS'(VALUE_WIDTH + 1)))
      else $error("character count out of range");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (load_out && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("final character did not return to idle");

endmodule

// ===== hdl/sra_divider.sv =====
// Iterative divider by a small radix, eight quotient bits per cycle.
module sra_divider #(
   parameter int unsigned VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DFLT
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   start,
   input  logic [((VALUE_WIDTH+sra_pkg::STEP_BITS-1)/sra_pkg::STEP_BITS)
                 *sra_pkg::STEP_BITS-1:0]                         operand,
   input  logic [sra_pkg::RADIX_BITS-1:0]                         radix,
   output logic                                                   done,
   output logic [((VALUE_WIDTH+sra_pkg::STEP_BITS-1)/sra_pkg::STEP_BITS)
                 *sra_pkg::STEP_BITS-1:0]                         quotient,
   output logic [sra_pkg::DIGIT_BITS-1:0]                         remainder
);
   import sra_pkg::*;

   localparam int unsigned DIV_STEPS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int unsigned PAD_WIDTH  = DIV_STEPS * STEP_BITS;
   localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS + 1);

   logic [PAD_WIDTH-1:0]  work_ff, work_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic [STEP_BITS-1:0]  top_bits, qbits;
   logic [DIGIT_BITS:0]   trial;

   // restoring division of the top byte, one radix compare per bit
   always_comb begin
      top_bits = work_ff[PAD_WIDTH-1 -: STEP_BITS];
      rem_in   = rem_ff;
      qbits    = '0;
      trial    = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {rem_in, top_bits[i]};
         if (trial >= radix) begin
            rem_in   = DIGIT_BITS'(trial - radix);
            qbits[i] = 1'b1;
         end else begin
            rem_in   = trial[DIGIT_BITS-1:0];
         end
      end
      work_in = (work_ff << STEP_BITS) | PAD_WIDTH'(qbits);
   end

   assign done      = busy_ff && (step_ff == STEP_CNT_W'(DIV_STEPS - 1));
   assign quotient  = work_in;
   assign remainder = rem_in;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + STEP_CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= operand;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

// ===== tb/signed_radix_to_ascii_tb.sv =====
// Self-checking testbench for the signed radix-to-ASCII converter.
`timescale 1ns / 100ps

module signed_radix_to_ascii_tb;
   import sra_pkg::*;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 250;
   localparam int unsigned PHASE_ITEMS = 23;
   localparam int unsigned PHASES      = 8;

   typedef struct packed {
      logic [CHAR_BITS-1:0]       character;
      logic [CHAR_COUNT_BITS-1:0] char_count;
      logic                       last;
   } char_beat_type;

   typedef struct packed {
      logic [RADIX_BITS-1:0] base;
      logic                  upper;
      logic [VALUE_BITS-1:0] value;
   } directed_type;

   class radix_text_scoreboard;
      logic [RADIX_BITS-1:0] radix      = RADIX_RESET;
      logic                  upper_case = 1'b0;
      char_beat_type         expected_chars[$];
      int unsigned           mismatches = 0;

      function int unsigned effective_radix();
         if (radix < 2) begin
            return 2;
         end else if (radix > 16) begin
            return 16;
         end
         return radix;
      endfunction

      function void note_value(input logic signed [VALUE_BITS-1:0] value);
         logic [VALUE_BITS-1:0] mag;
         logic [DIGIT_BITS-1:0] digits[$];
         logic [DIGIT_BITS-1:0] d;
         int unsigned           base;
         char_beat_type         beat;
         logic [CHAR_COUNT_BITS-1:0] count;
         base = effective_radix();
         mag = value[VALUE_BITS-1] ? VALUE_BITS'(-value) : value;
         count = '0;
         do begin
            digits.push_back(DIGIT_BITS'(mag % base));
            mag = mag / base;
         end while (mag != 0);
         if (value[VALUE_BITS-1]) begin
            count++;
            beat.character  = CHAR_MINUS;
            beat.char_count = count;
            beat.last       = 1'b0;
            expected_chars.push_back(beat);
         end
         for (int i = digits.size() - 1; i >= 0; i--) begin
            d = digits[i];
            count++;
            if (d < 10) begin
               beat.character = CHAR_ZERO + CHAR_BITS'(d);
            end else if (upper_case) begin
               beat.character = CHAR_UPPER_A + CHAR_BITS'(d - 10);
            end else begin
               beat.character = CHAR_LOWER_A + CHAR_BITS'(d - 10);
            end
            beat.char_count = count;
            beat.last       = (i == 0);
            expected_chars.push_back(beat);
         end
      endfunction

      function void check_char(input logic [CHAR_BITS-1:0] character,
                               input logic [CHAR_COUNT_BITS-1:0] char_count,
                               input logic last);
         char_beat_type want;
         if (expected_chars.size() == 0) begin
            $error("unexpected item: character %h char_count %0d last %b",
                   character, char_count, last);
            mismatches++;
            return;
         end
         want = expected_chars.pop_front();
         if (character !== want.character) begin
            $error("character: expected %h, got %h", want.character, character);
            mismatches++;
         end
         if (char_count !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count, char_count);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   int unsigned rsp_hold_cycles = 0;

   radix_text_scoreboard text_sb = new;

   sra_req_if req();
   sra_rsp_if rsp();

   signed_radix_to_ascii dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   directed_type directed_list[24] = '{
      '{5'd10, 1'b0, 32'd0},
      '{5'd10, 1'b0, 32'd1},
      '{5'd10, 1'b0, -32'sd1},
      '{5'd10, 1'b0, 32'h7FFFFFFF},
      '{5'd10, 1'b0, 32'h80000000},
      '{5'd10, 1'b0, 32'd9},
      '{5'd10, 1'b0, 32'd10},
      '{5'd10, 1'b0, -32'sd1234567890},
      '{5'd16, 1'b0, 32'd10},
      '{5'd16, 1'b0, 32'd15},
      '{5'd16, 1'b0, 32'd16},
      '{5'd16, 1'b0, 32'd255},
      '{5'd16, 1'b0, 32'hDEADBEEF},
      '{5'd16, 1'b0, 32'h7FFFFFFF},
      '{5'd16, 1'b1, 32'h00ABCDEF},
      '{5'd16, 1'b1, 32'h80000000},
      '{5'd16, 1'b1, 32'hFEDCBA98},
      '{5'd2,  1'b0, 32'h80000000},
      '{5'd2,  1'b0, 32'h7FFFFFFF},
      '{5'd0,  1'b0, 32'd5},
      '{5'd31, 1'b1, 32'd250},
      '{5'd1,  1'b0, -32'sd3},
      '{5'd17, 1'b1, -32'sd171},
      '{5'd7,  1'b0, 32'd48}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [VALUE_BITS-1:0] pick_value(input int unsigned base);
      logic [VALUE_BITS-1:0] v;
      int unsigned k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4: v = $urandom_range(0, base * base);
         5: v = -$urandom_range(0, base * base * base);
         6: begin
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = '1;
               2: v = 32'h7FFFFFFF;
               default: v = 32'h80000000;
            endcase
         end
         7: begin
            v = 1;
            k = $urandom_range(1, 31);
            repeat (k) begin
               if (v <= 32'hFFFFFFFF / base) v = v * base;
            end
            v = v + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
      if (req_gaps) begin
         while ($urandom_range(0, 99) < 35) begin
            req.valid <= 1'b0;
            req.value <= $urandom;
            @(posedge clock);
         end
      end
      req.valid <= 1'b1;
      req.value <= value;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      text_sb.note_value(value);
   endtask

   // drop valid, wait for every pending item, then let the block settle
   task automatic settle();
      req.valid <= 1'b0;
      while (text_sb.expected_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_WIDTH-1:0] base,
                             input logic [CSR_DATA_WIDTH-1:0] case_word);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_RADIX;
      csr_write_data <= base;
      @(posedge clock);
      csr_index      <= CSR_UPPER_CASE;
      csr_write_data <= case_word;
      @(posedge clock);
      csr_write_en <= 1'b0;
      text_sb.radix      = base;
      text_sb.upper_case = case_word[0];
   endtask

   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            text_sb.check_char(rsp.character, rsp.char_count, rsp.last);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= !rsp_gaps || ($urandom_range(0, 99) >= 35);
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [CSR_DATA_WIDTH-1:0] base;
      logic [CSR_DATA_WIDTH-1:0] case_word;
      req.valid      <= 1'b0;
      req.value      <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_RADIX;
      csr_write_data <= '0;
      reset          <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_config(RADIX_RESET, 5'd0);

      foreach (directed_list[i]) begin
         if (directed_list[i].base != text_sb.radix ||
             directed_list[i].upper != text_sb.upper_case) begin
            settle();
            set_config(directed_list[i].base, {4'b0, directed_list[i].upper});
         end
         send_value(directed_list[i].value);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: base = 5'd2;
            1: base = 5'd16;
            2: base = 5'd10;
            3: base = 5'd0;
            4: base = 5'd31;
            default: base = 5'($urandom_range(1, 17));
         endcase
         case_word = {4'($urandom_range(0, 15)), 1'(phase & 1)};
         set_config(base, case_word);
         req_gaps = (phase != 2);
         rsp_gaps = (phase != 2);
         if (phase == 5) rsp_hold_cycles = HOLD_CYCLES;
         repeat (PHASE_ITEMS) send_value(pick_value(text_sb.effective_radix()));
      end

      req.valid <= 1'b0;
      while (text_sb.expected_chars.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (text_sb.mismatches == 0 && text_sb.expected_chars.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sra_pkg.sv
hdl/sra_req_if.sv
hdl/sra_rsp_if.sv
hdl/sra_divider.sv
hdl/signed_radix_to_ascii.sv
tb/signed_radix_to_ascii_tb.sv
